[hdl/assert_macros.svh]
// assertion helpers shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and synchronous reset
`define SEM_ASSERT_ON(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// same, on the usual clock and reset names
`define SEM_ASSERT(lbl, prop, msg) `SEM_ASSERT_ON(lbl, clock, reset, prop, msg)

`endif

[hdl/sem_pkg.sv]
package sem_pkg;

   localparam int OFFSET_W    = 48;
   localparam int LENGTH_W    = 32;
   localparam int TARGET_W    = 6;
   localparam int TCOUNT_W    = 7;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int REG_SEL_BIT = 2;
   localparam int DIVIDEND_W  = OFFSET_W + 1;
   localparam int DIVISOR_W   = 32;

   localparam int EXTENT_CAP_DEF = 16;

   localparam logic [LENGTH_W-1:0] STRIPE_BYTES_RST = 32'd1048576;
   localparam logic [TCOUNT_W-1:0] TARGET_COUNT_RST = 7'd4;
   localparam logic [TCOUNT_W-1:0] TARGET_COUNT_MAX = 7'd64;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   typedef enum logic {
      REG_STRIPE_BYTES = 1'b0,
      REG_TARGET_COUNT = 1'b1
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLAMP,
      ST_START,
      ST_DIV_POS,
      ST_START_TGT,
      ST_DIV_TGT,
      ST_EMIT,
      ST_NONE
   } state_type;

   typedef struct packed {
      logic                operation;
      logic [OFFSET_W-1:0] byte_offset;
      logic [LENGTH_W-1:0] byte_length;
      logic [TARGET_W-1:0] first_target;
      logic [OFFSET_W-1:0] file_size;
   } req_payload_type;

   typedef struct packed {
      logic                extent_valid;
      logic [TARGET_W-1:0] target_index;
      logic [OFFSET_W-1:0] stripe_number;
      logic [LENGTH_W-1:0] offset_in_stripe;
      logic [LENGTH_W-1:0] extent_length;
      logic [OFFSET_W-1:0] file_position;
      logic                last_extent;
   } rsp_payload_type;

endpackage

[hdl/sem_divider.sv]
module sem_divider
   import sem_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic [DIVISOR_W-1:0]  remainder
);

   localparam int STEP_W = $clog2(DIVIDEND_W);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  div_ff, div_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   // one quotient bit per cycle, restoring
   always_comb begin
      trial   = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff    = trial - {1'b0, div_ff};
      fits    = trial >= {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(DIVIDEND_W - 1);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in  = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         step_in = step_ff - STEP_W'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

[hdl/stripe_extent_mapper.sv]
// Maps a byte region of a striped file onto round-robin targets and returns one beat per
// extent, no extent crossing a stripe boundary; reads are clamped to the file size, at most
// EXTENT_CAP extents come out per request, and a request covering nothing gives one beat
// with extent_valid low. Each request goes through the accepting state and a clamping step, then
// two passes through the shared bit-serial divider (each a start, the quotient bits and a
// result; offset by stripe size, then stripe plus first target by target count), then one
// extent per cycle while the output register is free. A request covering nothing skips the
// divider, and stalls on the result side hold the block. req_ready is high only between
// requests; the last beat may still wait in the output register while the next request is
// accepted.
module stripe_extent_mapper
   import sem_pkg::*;
#(
   parameter int EXTENT_CAP = EXTENT_CAP_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CNT_W = $clog2(EXTENT_CAP + 1);

   state_type state_ff, state_in;

   logic [LENGTH_W-1:0] sb_ff, sb_in;
   logic [TCOUNT_W-1:0] tc_ff, tc_in;
   logic [LENGTH_W-1:0] sb_eff;
   logic [TCOUNT_W-1:0] tc_eff;
   csr_reg_type         csr_sel;
   logic                csr_wr;

   req_payload_type     req_ff, req_in;
   logic [OFFSET_W-1:0] pos_ff, pos_in;
   logic [LENGTH_W-1:0] rem_ff, rem_in;
   logic [OFFSET_W-1:0] stripe_ff, stripe_in;
   logic [LENGTH_W-1:0] within_ff, within_in;
   logic [TARGET_W-1:0] tgt_ff, tgt_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_data_ff, rsp_data_in;

   logic                out_free;
   logic                accept;
   logic                div_start;
   logic                div_done;
   logic [DIVIDEND_W-1:0] div_dividend;
   logic [DIVISOR_W-1:0]  div_divisor;
   logic [DIVIDEND_W-1:0] div_quotient;
   logic [DIVISOR_W-1:0]  div_remainder;

   logic [DIVIDEND_W-1:0] limit;
   logic [LENGTH_W-1:0]   room;
   logic [LENGTH_W-1:0]   ext_len;
   logic                  ext_last;
   logic [TCOUNT_W-1:0]   tgt_next;
   logic                  load_ext;
   logic                  load_none;

   // configuration
   assign csr_sel    = csr_reg_type'(csr_paddr[REG_SEL_BIT]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      sb_in      = sb_ff;
      tc_in      = tc_ff;
      csr_prdata = '0;
      unique case (csr_sel)
         REG_STRIPE_BYTES: begin
            csr_prdata = sb_ff;
            if (csr_wr) sb_in = csr_pwdata;
         end
         REG_TARGET_COUNT: begin
            csr_prdata = CSR_DATA_W'(tc_ff);
            if (csr_wr) tc_in = csr_pwdata[TCOUNT_W-1:0];
         end
         default: csr_prdata = '0;
      endcase
   end

   assign sb_eff = (sb_ff == '0) ? LENGTH_W'(1) : sb_ff;
   assign tc_eff = (tc_ff == '0) ? TCOUNT_W'(1) :
                   (tc_ff > TARGET_COUNT_MAX) ? TARGET_COUNT_MAX : tc_ff;

   // shared divider
   assign div_dividend = (state_ff == ST_START_TGT) ?
                         ({1'b0, stripe_ff} + DIVIDEND_W'(req_ff.first_target)) :
                         {1'b0, pos_ff};
   assign div_divisor  = (state_ff == ST_START_TGT) ? DIVISOR_W'(tc_eff) : sb_eff;

   sem_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign accept   = req_valid && req_ready;

   // extent arithmetic
   always_comb begin
      if (req_ff.operation == OP_WRITE) begin
         limit = {1'b1, {OFFSET_W{1'b0}}} - {1'b0, req_ff.byte_offset};
      end else if (req_ff.file_size > req_ff.byte_offset) begin
         limit = {1'b0, req_ff.file_size - req_ff.byte_offset};
      end else begin
         limit = '0;
      end
      room     = sb_eff - within_ff;
      ext_len  = (rem_ff < room) ? rem_ff : room;
      ext_last = (rem_ff == ext_len) || (count_ff == CNT_W'(EXTENT_CAP - 1));
      tgt_next = TCOUNT_W'(tgt_ff) + TCOUNT_W'(1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_CLAMP;
         ST_CLAMP:     state_in = ST_START;
         ST_START:     state_in = (rem_ff == '0) ? ST_NONE : ST_DIV_POS;
         ST_DIV_POS:   if (div_done) state_in = ST_START_TGT;
         ST_START_TGT: state_in = ST_DIV_TGT;
         ST_DIV_TGT:   if (div_done) state_in = ST_EMIT;
         ST_EMIT:      if (out_free && ext_last) state_in = ST_IDLE;
         ST_NONE:      if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      load_ext  = 1'b0;
      load_none = 1'b0;
      unique case (state_ff)
         ST_IDLE:      req_ready = 1'b1;
         ST_START:     div_start = (rem_ff != '0);
         ST_START_TGT: div_start = 1'b1;
         ST_EMIT:      load_ext  = out_free;
         ST_NONE:      load_none = out_free;
         default:      req_ready = 1'b0;
      endcase
   end

   // datapath
   always_comb begin
      req_in       = req_ff;
      pos_in       = pos_ff;
      rem_in       = rem_ff;
      stripe_in    = stripe_ff;
      within_in    = within_ff;
      tgt_in       = tgt_ff;
      count_in     = count_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (accept) begin
         req_in = req_data;
      end
      if (state_ff == ST_CLAMP) begin
         pos_in   = req_ff.byte_offset;
         count_in = '0;
         rem_in   = ({{(DIVIDEND_W-LENGTH_W){1'b0}}, req_ff.byte_length} < limit) ?
                    req_ff.byte_length : limit[LENGTH_W-1:0];
      end
      if (state_ff == ST_DIV_POS && div_done) begin
         stripe_in = div_quotient[OFFSET_W-1:0];
         within_in = div_remainder;
      end
      if (state_ff == ST_DIV_TGT && div_done) begin
         tgt_in = div_remainder[TARGET_W-1:0];
      end
      if (load_ext) begin
         rsp_valid_in                 = 1'b1;
         rsp_data_in.extent_valid     = 1'b1;
         rsp_data_in.target_index     = tgt_ff;
         rsp_data_in.stripe_number    = stripe_ff;
         rsp_data_in.offset_in_stripe = within_ff;
         rsp_data_in.extent_length    = ext_len;
         rsp_data_in.file_position    = pos_ff;
         rsp_data_in.last_extent      = ext_last;
         pos_in    = pos_ff + OFFSET_W'(ext_len);
         rem_in    = rem_ff - ext_len;
         stripe_in = stripe_ff + OFFSET_W'(1);
         within_in = '0;
         tgt_in    = (tgt_next == tc_eff) ? '0 : tgt_next[TARGET_W-1:0];
         count_in  = count_ff + CNT_W'(1);
      end
      if (load_none) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in              = '0;
         rsp_data_in.last_extent  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sb_ff        <= STRIPE_BYTES_RST;
         tc_ff        <= TARGET_COUNT_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sb_ff        <= sb_in;
         tc_ff        <= tc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      pos_ff      <= pos_in;
      rem_ff      <= rem_in;
      stripe_ff   <= stripe_in;
      within_ff   <= within_in;
      tgt_ff      <= tgt_in;
      count_ff    <= count_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hdl/sem_checker.sv]
`include "assert_macros.svh"

module sem_checker
   import sem_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_data
);

   // a stalled beat stays offered
   `SEM_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "rsp beat dropped while stalled")

   // one request at a time
   `SEM_ASSERT(a_req_single, req_valid && req_ready |=> !req_ready, "req taken while busy")

   // an empty result closes its request and carries nothing
   `SEM_ASSERT(a_empty_last, rsp_valid && !rsp_data.extent_valid |-> rsp_data.last_extent && rsp_data.extent_length == '0 && rsp_data.stripe_number == '0 && rsp_data.target_index == '0, "empty result malformed")

   // real extents are never empty
   `SEM_ASSERT(a_ext_len, rsp_valid && rsp_data.extent_valid |-> rsp_data.extent_length != '0, "zero length extent")

endmodule

bind stripe_extent_mapper sem_checker u_sem_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
